// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SRU elementwise block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define SRU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("SRU assertion failed");

// Next-cycle implication
`define SRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("SRU assertion failed");

// Invariant checked at every edge
`define SRU_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("SRU assertion failed");

`endif

// ===== src/sru_pkg.sv =====
// ---------------------------------------------------------------------------
// SRU package
// Widths, command codes, activation knot tables and fixed-point helpers.
// ---------------------------------------------------------------------------
package sru_pkg;

  // Storage and field widths
  localparam int POSITIONS = 4096;
  localparam int ADDR_W    = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int POS_W     = 12;
  localparam int DATA_W    = 16;
  localparam int FRAC_W    = 12;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  // Piecewise-linear activations (segment count is a power of two)
  localparam int ACT_SEGMENTS = 64;
  localparam int SEL_W     = $clog2(ACT_SEGMENTS);
  localparam int KIDX_W    = SEL_W + 1;
  localparam int OFF_W     = 16 - SEL_W;
  localparam int KNOT_W    = 14;
  localparam int PROD_W    = KNOT_W + OFF_W + 2;
  localparam int OFF_MASK  = (1 << OFF_W) - 1;

  // Result queue
  localparam int OUT_DEPTH = 16;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  // Commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef logic signed [DATA_W-1:0] q12_t;
  typedef logic signed [KNOT_W-1:0] knot_t;
  typedef knot_t knot_tab_t [ACT_SEGMENTS+1];

  localparam q12_t Q12_MAX = 16'sh7FFF;
  localparam q12_t Q12_MIN = 16'sh8000;

  typedef struct packed {
    knot_t                   y0;
    logic signed [KNOT_W:0]  dy;
    logic [OFF_W-1:0]        off;
  } pwl_seg_t;

  typedef struct packed {
    q12_t             hidden_out;
    logic [POS_W-1:0] out_position;
  } out_beat_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // exp(-a) for a in Q12, result Q30: fourth-order series then eight squarings
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
    logic [63:0] y, y2, y3, y4, v;
    int i;
    y  = a << 10;
    y2 = (y * y) >> 30;
    y3 = (y2 * y) >> 30;
    y4 = (y3 * y) >> 30;
    v  = Q30_ONE + y2 / 2 + y4 / 24 - y - y3 / 6;
    for (i = 0; i < 8; i++) begin
      v = (v * v) >> 30;
    end
    return v;
  endfunction

  // Restoring long division for building the knot tables
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    int i;
    q   = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Knot values over [-8,8], rounded to Q.12
  function automatic knot_tab_t build_knots(input logic is_tanh);
    knot_tab_t   tab;
    int          k;
    longint      x;
    logic [63:0] a, e, den, p;
    for (k = 0; k <= ACT_SEGMENTS; k++) begin
      x = (longint'(k) * 65536) / ACT_SEGMENTS - 32768;
      a = 64'((x < 0) ? -x : x);
      if (is_tanh) begin
        e   = exp_neg_q30(a << 1);
        den = Q30_ONE + e;
        p   = long_div(((Q30_ONE - e) << 12) + den / 2, den);
        tab[k] = (x >= 0) ? KNOT_W'(p) : KNOT_W'(64'd0 - p);
      end else begin
        e   = exp_neg_q30(a);
        den = Q30_ONE + e;
        p   = long_div((Q30_ONE << 12) + den / 2, den);
        tab[k] = (x >= 0) ? KNOT_W'(p) : KNOT_W'(64'd4096 - p);
      end
    end
    return tab;
  endfunction

  localparam knot_tab_t SIG_KNOTS  = build_knots(1'b0);
  localparam knot_tab_t TANH_KNOTS = build_knots(1'b1);

  function automatic q12_t sat16(input logic signed [31:0] v);
    q12_t r;
    if (v > 32'(Q12_MAX)) begin
      r = Q12_MAX;
    end else if (v < 32'(Q12_MIN)) begin
      r = Q12_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic q12_t sat_add(input q12_t a, input q12_t b);
    logic signed [31:0] s;
    s = 32'(a) + 32'(b);
    return sat16(s);
  endfunction

  // Segment select and knot lookup for one activation input
  function automatic pwl_seg_t pwl_seg(input q12_t x, input logic use_tanh);
    logic [15:0]       u;
    logic [KIDX_W-1:0] k0, k1;
    knot_t             y0, y1;
    pwl_seg_t          seg;
    u  = {~x[DATA_W-1], x[DATA_W-2:0]};
    k0 = {1'b0, u[15 -: SEL_W]};
    k1 = k0 + 1'b1;
    y0 = use_tanh ? TANH_KNOTS[k0] : SIG_KNOTS[k0];
    y1 = use_tanh ? TANH_KNOTS[k1] : SIG_KNOTS[k1];
    seg.y0  = y0;
    seg.dy  = $signed({y1[KNOT_W-1], y1}) - $signed({y0[KNOT_W-1], y0});
    seg.off = u[OFF_W-1:0];
    return seg;
  endfunction

  function automatic logic signed [PROD_W-1:0] pwl_mul(input pwl_seg_t seg);
    return PROD_W'($signed(seg.dy)) * PROD_W'($signed({1'b0, seg.off}));
  endfunction

  // Add the interpolated step, quotient truncated toward zero
  function automatic knot_t pwl_finish(input knot_t y0, input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] adj;
    adj = prod[PROD_W-1] ? (prod + PROD_W'(OFF_MASK)) : prod;
    return y0 + KNOT_W'(adj >>> OFF_W);
  endfunction

  // g*a + (1-g)*b as g*(a-b) + b, rounded half up, saturated
  function automatic q12_t blend(input knot_t g, input q12_t a, input q12_t b);
    logic signed [DATA_W:0] d;
    logic signed [31:0]     t;
    d = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    t = 32'(g) * 32'(d) + (32'(b) <<< FRAC_W) + 32'(ROUND_HALF);
    return sat16(t >>> FRAC_W);
  endfunction

endpackage

// ===== src/sru_in_if.sv =====
// ---------------------------------------------------------------------------
// SRU input channel
// Valid/ready channel carrying one load or step beat.
// ---------------------------------------------------------------------------
interface sru_in_if;
  import sru_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [POS_W-1:0] position;
  q12_t             initial_cell;
  q12_t             bias_forget;
  q12_t             bias_reset;
  q12_t             candidate_in;
  q12_t             forget_pre;
  q12_t             reset_pre;
  q12_t             highway_in;
  logic             last_step;

  modport source (
    output valid, command, position, initial_cell, bias_forget, bias_reset,
           candidate_in, forget_pre, reset_pre, highway_in, last_step,
    input  ready
  );

  modport sink (
    input  valid, command, position, initial_cell, bias_forget, bias_reset,
           candidate_in, forget_pre, reset_pre, highway_in, last_step,
    output ready
  );
endinterface

// ===== src/sru_out_if.sv =====
// ---------------------------------------------------------------------------
// SRU output channel
// Valid/ready channel carrying one hidden output beat.
// ---------------------------------------------------------------------------
interface sru_out_if;
  import sru_pkg::*;

  logic             valid;
  logic             ready;
  q12_t             hidden_out;
  logic [POS_W-1:0] out_position;

  modport source (output valid, hidden_out, out_position, input ready);
  modport sink   (input valid, hidden_out, out_position, output ready);
endinterface

// ===== src/sru_cell_elementwise.sv =====
// ---------------------------------------------------------------------------
// SRU cell, elementwise stage
// Gate activations, per-position cell update and hidden output blend.
// ---------------------------------------------------------------------------
// Path: a step beat runs through the pipeline, and an emitted result enters the queue.
// Throughput: one beat per cycle when not stalled, set by the cell update loop through the
//   cell RAM with forwarding from the stage behind it; same position back to back is fine.
// Input stalls only when the result queue could overflow under output back-pressure.
// Reset clears pipeline valids and the result queue and sets emit_all_steps to 1;
//   RAMs not cleared: the user must load every position before its first step, unchecked.
`include "assert_macros.svh"

module sru_cell_elementwise (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  sru_in_if.sink    item,
  sru_out_if.source result
);
  import sru_pkg::*;

  localparam int PIPE_STAGES = 8;
  localparam int OCC_W       = $clog2(OUT_DEPTH + PIPE_STAGES + 1);

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic cmd;
    pos_t pos;
    q12_t init_cell;
    q12_t bias_f;
    q12_t bias_r;
    q12_t cand;
    q12_t f_pre;
    q12_t r_pre;
    q12_t hw;
    logic last;
  } st1_t;

  typedef struct packed {
    logic     cmd;
    pos_t     pos;
    q12_t     init_cell;
    q12_t     bias_f;
    q12_t     bias_r;
    q12_t     cand;
    q12_t     hw;
    logic     last;
    pwl_seg_t f_seg;
    pwl_seg_t r_seg;
  } st2_t;

  typedef struct packed {
    logic                     cmd;
    pos_t                     pos;
    q12_t                     init_cell;
    q12_t                     cand;
    q12_t                     hw;
    logic                     last;
    knot_t                    f_y0;
    logic signed [PROD_W-1:0] f_prod;
    knot_t                    r_y0;
    logic signed [PROD_W-1:0] r_prod;
  } st3_t;

  typedef struct packed {
    logic  cmd;
    pos_t  pos;
    q12_t  init_cell;
    q12_t  cand;
    q12_t  hw;
    logic  last;
    knot_t f;
    knot_t r;
  } st4_t;

  typedef struct packed {
    logic  cmd;
    pos_t  pos;
    q12_t  cell_val;
    q12_t  hw;
    logic  last;
    knot_t r;
  } st5_t;

  typedef struct packed {
    logic     cmd;
    pos_t     pos;
    q12_t     hw;
    logic     last;
    knot_t    r;
    pwl_seg_t t_seg;
  } st6_t;

  typedef struct packed {
    logic                     cmd;
    pos_t                     pos;
    q12_t                     hw;
    logic                     last;
    knot_t                    r;
    knot_t                    t_y0;
    logic signed [PROD_W-1:0] t_prod;
  } st7_t;

  typedef struct packed {
    logic  cmd;
    pos_t  pos;
    q12_t  hw;
    logic  last;
    knot_t r;
    knot_t th;
  } st8_t;

  logic                 emit_all_steps;
  logic [PIPE_STAGES:1] vld;
  st1_t s1;
  st2_t s2;
  st3_t s3;
  st4_t s4;
  st5_t s5;
  st6_t s6;
  st7_t s7;
  st8_t s8;

  logic                  take;
  logic [OUT_CNT_W-1:0]  fifo_cnt;
  logic [OCC_W-1:0]      occ;
  logic [2*DATA_W-1:0]   bias_rd;
  logic                  bias_we;
  logic                  bias_fwd;
  q12_t                  bias_f_cur;
  q12_t                  bias_r_cur;
  logic [DATA_W-1:0]     cell_rd;
  q12_t                  cell_old;
  q12_t                  cell_new;
  q12_t                  th_ext;
  logic                  push;
  out_beat_t             push_beat;

  // Accept while the queue has room for everything in flight
  assign occ        = OCC_W'($countones(vld)) + OCC_W'(fifo_cnt);
  assign item.ready = (occ < OCC_W'(OUT_DEPTH));
  assign take       = item.valid && item.ready && (32'(item.position) < POSITIONS);

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_all_steps <= 1'b1;
    end else if (cfg_we) begin
      emit_all_steps <= cfg_wdata;
    end
  end

  // Advance the valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_STAGES-1:1], take};
    end
  end

  // Bias RAM: read as the beat is accepted, loads write in stage 1
  assign bias_we = vld[1] && (s1.cmd == CMD_LOAD);

  sru_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (POSITIONS)
  ) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (s1.pos[ADDR_W-1:0]),
    .wdata ({s1.bias_f, s1.bias_r}),
    .raddr (item.position[ADDR_W-1:0]),
    .rdata (bias_rd)
  );

  // Forward biases from a load one beat ahead at the same position
  assign bias_fwd   = vld[2] && (s2.cmd == CMD_LOAD) && (s2.pos == s1.pos);
  assign bias_f_cur = bias_fwd ? s2.bias_f : bias_rd[2*DATA_W-1:DATA_W];
  assign bias_r_cur = bias_fwd ? s2.bias_r : bias_rd[DATA_W-1:0];

  // Cell RAM: read in the cycle before the update stage, written in stage 4
  sru_ram #(
    .WIDTH (DATA_W),
    .DEPTH (POSITIONS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (vld[4]),
    .waddr (s4.pos[ADDR_W-1:0]),
    .wdata (cell_new),
    .raddr (s3.pos[ADDR_W-1:0]),
    .rdata (cell_rd)
  );

  // Cell update: take the fresh value of a beat just written at the same position
  assign cell_old = (vld[5] && (s5.pos == s4.pos)) ? s5.cell_val : q12_t'(cell_rd);
  assign cell_new = (s4.cmd == CMD_LOAD) ? s4.init_cell : blend(s4.f, cell_old, s4.cand);

  // Hidden output blend and queue push
  assign th_ext                 = DATA_W'(s8.th);
  assign push                   = vld[8] && (s8.cmd == CMD_STEP) && (emit_all_steps || s8.last);
  assign push_beat.hidden_out   = blend(s8.r, th_ext, s8.hw);
  assign push_beat.out_position = s8.pos;

  // Datapath stages
  always_ff @(posedge clk) begin
    // stage 1: capture the beat
    s1.cmd       <= item.command;
    s1.pos       <= item.position;
    s1.init_cell <= item.initial_cell;
    s1.bias_f    <= item.bias_forget;
    s1.bias_r    <= item.bias_reset;
    s1.cand      <= item.candidate_in;
    s1.f_pre     <= item.forget_pre;
    s1.r_pre     <= item.reset_pre;
    s1.hw        <= item.highway_in;
    s1.last      <= item.last_step;

    // stage 2: gate sums and knot lookup
    s2.cmd       <= s1.cmd;
    s2.pos       <= s1.pos;
    s2.init_cell <= s1.init_cell;
    s2.bias_f    <= s1.bias_f;
    s2.bias_r    <= s1.bias_r;
    s2.cand      <= s1.cand;
    s2.hw        <= s1.hw;
    s2.last      <= s1.last;
    s2.f_seg     <= pwl_seg(sat_add(s1.f_pre, bias_f_cur), 1'b0);
    s2.r_seg     <= pwl_seg(sat_add(s1.r_pre, bias_r_cur), 1'b0);

    // stage 3: interpolation products
    s3.cmd       <= s2.cmd;
    s3.pos       <= s2.pos;
    s3.init_cell <= s2.init_cell;
    s3.cand      <= s2.cand;
    s3.hw        <= s2.hw;
    s3.last      <= s2.last;
    s3.f_y0      <= s2.f_seg.y0;
    s3.f_prod    <= pwl_mul(s2.f_seg);
    s3.r_y0      <= s2.r_seg.y0;
    s3.r_prod    <= pwl_mul(s2.r_seg);

    // stage 4: gate values
    s4.cmd       <= s3.cmd;
    s4.pos       <= s3.pos;
    s4.init_cell <= s3.init_cell;
    s4.cand      <= s3.cand;
    s4.hw        <= s3.hw;
    s4.last      <= s3.last;
    s4.f         <= pwl_finish(s3.f_y0, s3.f_prod);
    s4.r         <= pwl_finish(s3.r_y0, s3.r_prod);

    // stage 5: hold the new cell
    s5.cmd       <= s4.cmd;
    s5.pos       <= s4.pos;
    s5.cell_val  <= cell_new;
    s5.hw        <= s4.hw;
    s5.last      <= s4.last;
    s5.r         <= s4.r;

    // stage 6: tanh knot lookup
    s6.cmd       <= s5.cmd;
    s6.pos       <= s5.pos;
    s6.hw        <= s5.hw;
    s6.last      <= s5.last;
    s6.r         <= s5.r;
    s6.t_seg     <= pwl_seg(s5.cell_val, 1'b1);

    // stage 7: tanh product
    s7.cmd       <= s6.cmd;
    s7.pos       <= s6.pos;
    s7.hw        <= s6.hw;
    s7.last      <= s6.last;
    s7.r         <= s6.r;
    s7.t_y0      <= s6.t_seg.y0;
    s7.t_prod    <= pwl_mul(s6.t_seg);

    // stage 8: tanh value
    s8.cmd       <= s7.cmd;
    s8.pos       <= s7.pos;
    s8.hw        <= s7.hw;
    s8.last      <= s7.last;
    s8.r         <= s7.r;
    s8.th        <= pwl_finish(s7.t_y0, s7.t_prod);
  end

  sru_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .count     (fifo_cnt),
    .result    (result)
  );

  `SRU_ASSERT_IMPL(a_push_from_step, clk, rst, push, $past(take && (item.command == CMD_STEP), PIPE_STAGES))
  `SRU_ASSERT_ALWAYS(a_credit_bound, clk, rst, occ <= OCC_W'(OUT_DEPTH))

endmodule

// ===== src/sru_ram.sv =====
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sru_out_fifo.sv =====
// ---------------------------------------------------------------------------
// SRU result queue
// Small FIFO between the datapath and the output channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sru_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  sru_pkg::out_beat_t             push_beat,
  output logic [sru_pkg::OUT_CNT_W-1:0]  count,
  sru_out_if.source                      result
);
  import sru_pkg::*;

  out_beat_t            entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 pop;

  assign pop                 = result.valid && result.ready;
  assign result.valid        = (count != '0);
  assign result.hidden_out   = entries[rd_ptr].hidden_out;
  assign result.out_position = entries[rd_ptr].out_position;

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_beat;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SRU_ASSERT_IMPL(a_no_overflow, clk, rst, push, count < OUT_CNT_W'(OUT_DEPTH))
  `SRU_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - 1'b1)

endmodule

// ===== dv/sru_elementwise_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SRU elementwise checker
// Watches the input, output and configuration ports of the elementwise
// stage. Predicts every hidden output from its own gate tables and
// per-position store, then compares output beats in order.
// ---------------------------------------------------------------------------
module sru_elementwise_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  sru_in_if    item,
  sru_out_if   result,
  output int   fail_count,
  output int   results_pending
);
  import sru_pkg::*;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // Knot values of the two activations, Q.12
  int        sig_tab  [ACT_SEGMENTS+1];
  int        tanh_tab [ACT_SEGMENTS+1];

  // Per-position cell state and gate biases
  q12_t      cell_mem  [POSITIONS];
  q12_t      fbias_mem [POSITIONS];
  q12_t      rbias_mem [POSITIONS];

  logic      emit_every_step;
  out_beat_t hidden_expected [$];

  // exp(-a) with a in Q12: series in a/256, then raised to the 256th power
  function automatic longint unsigned decay_q30(input longint unsigned a);
    longint unsigned y, y2, y3, y4, v;
    int i;
    y  = a << 10;
    y2 = (y * y) >> 30;
    y3 = (y2 * y) >> 30;
    y4 = (y3 * y) >> 30;
    v  = ONE_Q30 + y2 / 2 + y4 / 24 - y - y3 / 6;
    for (i = 0; i < 8; i++) begin
      v = (v * v) >> 30;
    end
    return v;
  endfunction

  function automatic q12_t clamp16(input longint v);
    if (v > 32767) begin
      return Q12_MAX;
    end
    if (v < -32768) begin
      return Q12_MIN;
    end
    return q12_t'(v);
  endfunction

  // Piecewise-linear lookup, interpolation step truncated toward zero
  function automatic int interp_act(input bit use_tanh, input int x);
    longint u, s, u0, span, y0, y1;
    u = longint'(x) + 32768;
    s = (u * ACT_SEGMENTS) >>> 16;
    if (s >= ACT_SEGMENTS) begin
      s = ACT_SEGMENTS - 1;
    end
    u0   = (s * 65536) / ACT_SEGMENTS;
    span = ((s + 1) * 65536) / ACT_SEGMENTS - u0;
    y0   = use_tanh ? tanh_tab[int'(s)]     : sig_tab[int'(s)];
    y1   = use_tanh ? tanh_tab[int'(s) + 1] : sig_tab[int'(s) + 1];
    return int'(y0 + ((y1 - y0) * (u - u0)) / span);
  endfunction

  // g*a + (1-g)*b with g in Q.12, rounded half up, saturated
  function automatic q12_t mix_q12(input int g, input int a, input int b);
    longint t;
    t = longint'(g) * a + longint'(4096 - g) * b + 2048;
    return clamp16(t >>> 12);
  endfunction

  // Build the knot tables over [-8,8]
  initial begin : build_tables
    int              k;
    longint          x;
    longint unsigned a, e, den, p;
    for (k = 0; k <= ACT_SEGMENTS; k++) begin
      x   = (longint'(k) * 65536) / ACT_SEGMENTS - 32768;
      a   = (x < 0) ? -x : x;
      e   = decay_q30(a);
      den = ONE_Q30 + e;
      p   = ((ONE_Q30 << 12) + den / 2) / den;
      sig_tab[k] = (x >= 0) ? int'(p) : 4096 - int'(p);
      e   = decay_q30(2 * a);
      den = ONE_Q30 + e;
      p   = (((ONE_Q30 - e) << 12) + den / 2) / den;
      tanh_tab[k] = (x >= 0) ? int'(p) : -int'(p);
    end
  end

  always @(posedge clk) begin : watch
    out_beat_t        want;
    logic [POS_W-1:0] pos;
    int               f, r, th;
    q12_t             cell_val, h;
    if (rst) begin
      emit_every_step = 1'b1;
      hidden_expected.delete();
      fail_count      = 0;
      results_pending = 0;
    end else begin
      // Compare an output beat with the oldest expectation
      if (result.valid && result.ready) begin
        if (hidden_expected.size() == 0) begin
          $error("unexpected output beat: hidden_out %0d, out_position %0d",
                 result.hidden_out, result.out_position);
          fail_count++;
        end else begin
          want = hidden_expected.pop_front();
          if (result.hidden_out !== want.hidden_out) begin
            $error("hidden_out: expected %0d, actual %0d", want.hidden_out,
                   result.hidden_out);
            fail_count++;
          end
          if (result.out_position !== want.out_position) begin
            $error("out_position: expected %0d, actual %0d", want.out_position,
                   result.out_position);
            fail_count++;
          end
        end
      end

      // Update the store, or predict the hidden output of a step beat
      if (item.valid && item.ready) begin
        pos = item.position;
        if (pos < POSITIONS) begin
          if (item.command == CMD_LOAD) begin
            cell_mem[pos]  = item.initial_cell;
            fbias_mem[pos] = item.bias_forget;
            rbias_mem[pos] = item.bias_reset;
          end else begin
            f  = interp_act(1'b0, clamp16(longint'(item.forget_pre) + fbias_mem[pos]));
            r  = interp_act(1'b0, clamp16(longint'(item.reset_pre) + rbias_mem[pos]));
            cell_val      = mix_q12(f, cell_mem[pos], item.candidate_in);
            cell_mem[pos] = cell_val;
            th = interp_act(1'b1, cell_val);
            h  = mix_q12(r, th, item.highway_in);
            if (emit_every_step || item.last_step) begin
              want.hidden_out   = h;
              want.out_position = pos;
              hidden_expected.push_back(want);
            end
          end
        end
      end

      if (cfg_we) begin
        emit_every_step = cfg_wdata;
      end
      results_pending = hidden_expected.size();
    end
  end

endmodule

// ===== dv/tb_sru_cell_elementwise.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SRU elementwise stage testbench
// Drives load and step beats into the block, first a directed set of
// extreme values, then random layer runs (load a group of positions, step
// them over several timesteps) mixed with stray and cut-short runs, under
// both emit settings and three idling patterns. The checker predicts and
// compares; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb_sru_cell_elementwise;
  import sru_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_BEATS   = 325;

  typedef struct packed {
    logic             command;
    logic [POS_W-1:0] position;
    q12_t             initial_cell;
    q12_t             bias_forget;
    q12_t             bias_reset;
    q12_t             candidate_in;
    q12_t             forget_pre;
    q12_t             reset_pre;
    q12_t             highway_in;
    logic             last_step;
  } sru_beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_count;
  int   results_pending;

  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_req;
  int   sent_beats;
  bit   loaded [POSITIONS];
  int   loaded_list [$];

  sru_in_if  item_bus ();
  sru_out_if hidden_bus ();

  sru_cell_elementwise dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_bus),
    .result    (hidden_bus)
  );

  sru_elementwise_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .item            (item_bus),
    .result          (hidden_bus),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q3.12 value: extremes, small values near the active range, or anything
  function automatic q12_t pick_q12();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      return Q12_MAX;
    end else if (sel == 1) begin
      return Q12_MIN;
    end else if (sel < 6) begin
      return q12_t'(int'($urandom_range(16383)) - 8192);
    end
    return q12_t'($urandom);
  endfunction

  // Offer one beat, idling first at random, and hold it until accepted
  task automatic send_beat(input sru_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.command      <= b.command;
    item_bus.position     <= b.position;
    item_bus.initial_cell <= b.initial_cell;
    item_bus.bias_forget  <= b.bias_forget;
    item_bus.bias_reset   <= b.bias_reset;
    item_bus.candidate_in <= b.candidate_in;
    item_bus.forget_pre   <= b.forget_pre;
    item_bus.reset_pre    <= b.reset_pre;
    item_bus.highway_in   <= b.highway_in;
    item_bus.last_step    <= b.last_step;
    item_bus.valid        <= 1'b1;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    @(negedge clk);
    sent_beats++;
  endtask

  // Load beat; the step fields carry noise
  task automatic send_load(input int pos, input q12_t cval, input q12_t bf, input q12_t br);
    sru_beat_t b;
    b.command      = CMD_LOAD;
    b.position     = POS_W'(pos);
    b.initial_cell = cval;
    b.bias_forget  = bf;
    b.bias_reset   = br;
    b.candidate_in = q12_t'($urandom);
    b.forget_pre   = q12_t'($urandom);
    b.reset_pre    = q12_t'($urandom);
    b.highway_in   = q12_t'($urandom);
    b.last_step    = 1'($urandom_range(1));
    send_beat(b);
    if (!loaded[pos]) begin
      loaded[pos] = 1'b1;
      loaded_list.push_back(pos);
    end
  endtask

  // Step beat; the load fields carry noise
  task automatic send_step(input int pos, input q12_t cand, input q12_t fp, input q12_t rp,
                           input q12_t hw, input logic last);
    sru_beat_t b;
    b.command      = CMD_STEP;
    b.position     = POS_W'(pos);
    b.initial_cell = q12_t'($urandom);
    b.bias_forget  = q12_t'($urandom);
    b.bias_reset   = q12_t'($urandom);
    b.candidate_in = cand;
    b.forget_pre   = fp;
    b.reset_pre    = rp;
    b.highway_in   = hw;
    b.last_step    = last;
    send_beat(b);
  endtask

  task automatic send_random_load(input int pos);
    if ($urandom_range(3) == 0) begin
      send_load(pos, pick_q12(), '0, '0);
    end else begin
      send_load(pos, pick_q12(), pick_q12(), pick_q12());
    end
  endtask

  // Layer run: load a group of positions, then step each one per timestep.
  // A cut-short run stops partway and never sends its final step.
  task automatic run_layer(input bit cut_short);
    int group [$];
    int n, steps, total, cut, t, i, pos;
    n     = $urandom_range(1, 8);
    steps = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(1) == 0) begin
        pos = $urandom_range(POSITIONS - 1);
      end else begin
        pos = loaded_list[$urandom_range(loaded_list.size() - 1)];
      end
      group.push_back(pos);
      send_random_load(pos);
    end
    total = n * steps;
    cut   = cut_short ? $urandom_range(total - 1) : total;
    for (t = 0; t < total && t < cut; t++) begin
      send_step(group[t % n], pick_q12(), pick_q12(), pick_q12(), pick_q12(),
                (t / n == steps - 1));
    end
  endtask

  task automatic run_random_burst();
    int sel;
    sel = $urandom_range(9);
    if (sel < 8) begin
      run_layer(1'b0);
    end else if (sel == 8) begin
      run_layer(1'b1);
    end else if ($urandom_range(1) == 0) begin
      send_step(loaded_list[$urandom_range(loaded_list.size() - 1)], pick_q12(),
                pick_q12(), pick_q12(), pick_q12(), 1'($urandom_range(1)));
    end else begin
      send_random_load($urandom_range(POSITIONS - 1));
    end
  endtask

  // Drop valid, wait for every expected beat, then let the pipe empty
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_emit(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_directed();
    // Loads: no biases, all high, all low, mid values on alternating bits
    send_load(0, '0, '0, '0);
    send_load(4095, Q12_MAX, Q12_MAX, Q12_MAX);
    send_load(2730, Q12_MIN, Q12_MIN, Q12_MIN);
    send_load(1365, 16'sd4096, -16'sd4096, 16'sd8192);
    // Steps: zero inputs, gate sums saturating high and low
    send_step(0, '0, '0, '0, '0, 1'b0);
    send_step(4095, Q12_MAX, Q12_MAX, Q12_MAX, Q12_MAX, 1'b1);
    send_step(4095, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN, 1'b0);
    send_step(2730, Q12_MAX, Q12_MIN, Q12_MIN, Q12_MAX, 1'b1);
    send_step(2730, Q12_MIN, Q12_MAX, Q12_MAX, Q12_MIN, 1'b0);
    send_step(1365, 16'sd12288, '0, '0, -16'sd12288, 1'b0);
    // Same position back to back
    repeat (3) send_step(1365, pick_q12(), pick_q12(), pick_q12(), pick_q12(), 1'b0);
    send_step(0, Q12_MIN, Q12_MAX, Q12_MIN, Q12_MAX, 1'b1);
    // Reload a stepped position
    send_load(0, Q12_MAX, '0, '0);
    send_step(0, Q12_MAX, Q12_MAX, Q12_MAX, Q12_MAX, 1'b1);
  endtask

  // Output side: random stalls, and a long hold-off for each request
  initial begin : result_sink
    int holds_done;
    holds_done       = 0;
    hidden_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        hidden_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      hidden_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // End the run if no beat moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (hidden_bus.valid && hidden_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int mode, emit, target;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = 1'b0;
    item_bus.valid        = 1'b0;
    item_bus.command      = CMD_LOAD;
    item_bus.position     = '0;
    item_bus.initial_cell = '0;
    item_bus.bias_forget  = '0;
    item_bus.bias_reset   = '0;
    item_bus.candidate_in = '0;
    item_bus.forget_pre   = '0;
    item_bus.reset_pre    = '0;
    item_bus.highway_in   = '0;
    item_bus.last_step    = 1'b0;
    send_idle_pct         = 15;
    recv_idle_pct         = 59;
    hold_req              = 0;
    sent_beats            = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    // Three idling patterns, each under both emit settings
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 59 : 0;
      recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 15 : 0;
      for (emit = 0; emit < 2; emit++) begin
        settle();
        write_emit(emit[0]);
        // With every step emitting, stall the output long enough to fill the block
        if (emit == 1) begin
          hold_req++;
        end
        target = sent_beats + PHASE_BEATS;
        while (sent_beats < target) run_random_burst();
      end
    end

    settle();
    if (fail_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
